// ===== sv/qts_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qts_pkg
// shared types and constants of the quoted token splitter
// ----------------------------------------------------------------------------
package qts_pkg;

  localparam int BYTE_W = 8;
  localparam int KIND_W = 2;
  localparam int FLAG_W = 10;
  localparam int NRES   = 3;
  localparam int CNT_W  = 2;

  // configuration port
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic REG_TOKEN_FLAGS = 1'b0;

  // result kinds
  localparam logic [KIND_W-1:0] K_BYTE = 2'd0;
  localparam logic [KIND_W-1:0] K_TEND = 2'd1;
  localparam logic [KIND_W-1:0] K_ERR  = 2'd2;

  // scan modes
  localparam logic [2:0] M_SKIP  = 3'd0;
  localparam logic [2:0] M_TOKEN = 3'd1;
  localparam logic [2:0] M_ESC   = 3'd2;
  localparam logic [2:0] M_CTRL  = 3'd3;
  localparam logic [2:0] M_DIG1  = 3'd4;
  localparam logic [2:0] M_DIG2  = 3'd5;
  localparam logic [2:0] M_CARET = 3'd6;

  // quote kinds
  localparam logic [1:0] Q_NONE   = 2'd0;
  localparam logic [1:0] Q_SINGLE = 2'd1;
  localparam logic [1:0] Q_DOUBLE = 2'd2;

  // flag bits
  localparam int F_KEEP_SPACE   = 0;
  localparam int F_KEEP_COMMENT = 1;
  localparam int F_STOP_PLUS    = 2;
  localparam int F_STOP_MINUS   = 3;
  localparam int F_STOP_EQUAL   = 4;
  localparam int F_STOP_QUEST   = 5;
  localparam int F_KEEP_SEMI    = 6;
  localparam int F_PATTERN      = 7;
  localparam int F_NO_QUOTE     = 8;
  localparam int F_CONDENSE     = 9;

  localparam logic [11:0]       OCTAL_BIAS = 12'd3504;
  localparam logic [BYTE_W-1:0] CTRL_MASK  = 8'h7f;
  localparam logic [BYTE_W-1:0] ESC_BYTE   = 8'h1b;
  localparam logic [BYTE_W-1:0] CARET_BASE = 8'h40;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] data;
    logic              last;
  } res_t;

endpackage
`default_nettype wire

// ===== sv/qts_in_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qts_in_if
// input channel: one line byte or a line-end marker per beat
// ----------------------------------------------------------------------------
interface qts_in_if import qts_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;
  logic              line_end;

  modport source (output valid, output in_byte, output line_end, input ready);
  modport sink   (input valid, input in_byte, input line_end, output ready);
endinterface
`default_nettype wire

// ===== sv/qts_out_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qts_out_if
// result channel: one decoded byte, token end or error per beat
// ----------------------------------------------------------------------------
interface qts_out_if import qts_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [BYTE_W-1:0] out_byte;
  logic              last;

  modport source (output valid, output kind, output out_byte, output last, input ready);
  modport sink   (input valid, input kind, input out_byte, input last, output ready);
endinterface
`default_nettype wire

// ===== sv/qts_cfg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qts_cfg
// register port holding the token flags
// ----------------------------------------------------------------------------
module qts_cfg import qts_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [CFG_DW-1:0] pwdata,
  output logic      [CFG_DW-1:0] prdata,
  output logic                   pready,
  output logic      [FLAG_W-1:0] flags
);

  logic [FLAG_W-1:0] flags_r;
  logic              wr_en;
  logic              reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[CFG_AW-1];
  assign wr_en   = psel & penable & pwrite & pready & (reg_idx == REG_TOKEN_FLAGS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
    end else if (wr_en) begin
      flags_r <= pwdata[FLAG_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == REG_TOKEN_FLAGS) begin
      prdata = {{(CFG_DW-FLAG_W){1'b0}}, flags_r};
    end
  end

  assign flags = flags_r;

endmodule
`default_nettype wire

// ===== sv/qts_decode.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qts_decode
// input register, scan state and per-byte decode into up to three results
// ----------------------------------------------------------------------------
module qts_decode import qts_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  qts_in_if.sink                     in_ch,
  input  wire logic [FLAG_W-1:0]     flags,
  input  wire logic                  buf_free,
  output logic                       load,
  output res_t      [NRES-1:0]       res,
  output logic      [CNT_W-1:0]      res_cnt
);

  typedef struct packed {
    logic              emit;
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] data;
    logic [2:0]        mode;
    logic [1:0]        quote;
  } pb_t;

  logic              in_vld_r;
  logic [BYTE_W-1:0] byte_r;
  logic              le_r;
  logic [2:0]        mode_r, mode_nxt;
  logic [1:0]        quote_r, quote_nxt;
  logic [BYTE_W-1:0] dig1_r, dig1_nxt;
  logic [BYTE_W-1:0] dig2_r, dig2_nxt;
  logic              in_fire;

  function automatic logic is_ws(input logic [BYTE_W-1:0] b);
    return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0d);
  endfunction

  function automatic logic is_digit(input logic [BYTE_W-1:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction

  function automatic logic is_alpha(input logic [BYTE_W-1:0] b);
    return (b >= 8'h41 && b <= 8'h5a) || (b >= 8'h61 && b <= 8'h7a);
  endfunction

  function automatic logic [BYTE_W-1:0] to_upper(input logic [BYTE_W-1:0] b);
    return (b >= 8'h61 && b <= 8'h7a) ? b - 8'h20 : b;
  endfunction

  function automatic logic stops(input logic [BYTE_W-1:0] b, input logic [FLAG_W-1:0] f);
    logic s;
    s = 1'b0;
    if (is_ws(b) && !f[F_KEEP_SPACE])   s = 1'b1;
    if (b == "#" && !f[F_KEEP_COMMENT]) s = 1'b1;
    if (b == "+" && f[F_STOP_PLUS])     s = 1'b1;
    if (b == "-" && f[F_STOP_MINUS])    s = 1'b1;
    if (b == "=" && f[F_STOP_EQUAL])    s = 1'b1;
    if (b == "?" && f[F_STOP_QUEST])    s = 1'b1;
    if (b == ";" && !f[F_KEEP_SEMI])    s = 1'b1;
    if (f[F_PATTERN] && (b == "~" || b == "%" || b == "=" || b == "!" || b == "|")) begin
      s = 1'b1;
    end
    return s;
  endfunction

  // ordinary byte inside a token; the mode it returns defaults to token
  function automatic pb_t plain(input logic [BYTE_W-1:0] b, input logic [1:0] q,
                                input logic [FLAG_W-1:0] f);
    pb_t p;
    p.emit  = 1'b0;
    p.kind  = K_BYTE;
    p.data  = b;
    p.mode  = M_TOKEN;
    p.quote = q;
    if (q == Q_NONE && stops(b, f)) begin
      p.emit = 1'b1;
      p.kind = K_TEND;
      p.mode = M_SKIP;
    end else if ((q == Q_SINGLE && b == "'") || (q == Q_DOUBLE && b == "\"")) begin
      p.quote = Q_NONE;
    end else if (q == Q_NONE && (b == "'" || b == "\"") && !f[F_NO_QUOTE]) begin
      p.quote = (b == "'") ? Q_SINGLE : Q_DOUBLE;
    end else if (b == "\\" && q != Q_SINGLE) begin
      p.mode = M_ESC;
    end else if (b == "^" && f[F_CONDENSE]) begin
      p.mode = M_CARET;
    end else begin
      p.emit = 1'b1;
    end
    return p;
  endfunction

  // ---------------- input register ----------------
  assign load        = in_vld_r & buf_free;
  assign in_ch.ready = ~in_vld_r | load;
  assign in_fire     = in_ch.valid & in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_fire) begin
      in_vld_r <= 1'b1;
    end else if (load) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      byte_r <= in_ch.in_byte;
      le_r   <= in_ch.line_end;
    end
  end

  // ---------------- decode ----------------
  always_comb begin
    logic [CNT_W-1:0]  n;
    logic [BYTE_W-1:0] b;
    logic [BYTE_W-1:0] oct;
    pb_t               p;
    logic              take_p;
    n         = '0;
    b         = byte_r;
    oct       = '0;
    p         = '0;
    take_p    = 1'b0;
    res       = '0;
    mode_nxt  = mode_r;
    quote_nxt = quote_r;
    dig1_nxt  = dig1_r;
    dig2_nxt  = dig2_r;

    if (le_r) begin
      if (mode_r == M_ESC || mode_r == M_CTRL || mode_r == M_CARET) begin
        res[n].kind = K_ERR; n = n + 1'b1;
      end else begin
        if (mode_r == M_DIG1 || mode_r == M_DIG2) begin
          res[n].kind = K_BYTE; res[n].data = dig1_r; n = n + 1'b1;
        end
        if (mode_r == M_DIG2) begin
          res[n].kind = K_BYTE; res[n].data = dig2_r; n = n + 1'b1;
        end
        res[n].kind = K_TEND; n = n + 1'b1;
      end
      mode_nxt  = M_SKIP;
      quote_nxt = Q_NONE;
      dig1_nxt  = '0;
      dig2_nxt  = '0;
    end else begin
      case (mode_r)
        M_SKIP: begin
          if (!is_ws(b)) begin
            p = plain(b, quote_r, flags);
            take_p = 1'b1;
          end
        end
        M_ESC: begin
          mode_nxt = M_TOKEN;
          res[n].kind = K_BYTE;
          if (b == "c" || b == "C") begin
            mode_nxt = M_CTRL;
          end else if (b == "e") begin
            res[n].data = ESC_BYTE; n = n + 1'b1;
          end else if (b == "f") begin
            res[n].data = 8'h0c; n = n + 1'b1;
          end else if (b == "n") begin
            res[n].data = 8'h0a; n = n + 1'b1;
          end else if (b == "r") begin
            res[n].data = 8'h0d; n = n + 1'b1;
          end else if (b == "t") begin
            res[n].data = 8'h09; n = n + 1'b1;
          end else if (is_digit(b)) begin
            dig1_nxt = b;
            mode_nxt = M_DIG1;
          end else begin
            res[n].data = b; n = n + 1'b1;
          end
        end
        M_CTRL: begin
          mode_nxt = M_TOKEN;
          res[n].kind = K_BYTE;
          res[n].data = (to_upper(b) - CARET_BASE) & CTRL_MASK;
          n = n + 1'b1;
        end
        M_DIG1: begin
          if (is_digit(b)) begin
            dig2_nxt = b;
            mode_nxt = M_DIG2;
          end else begin
            res[n].kind = K_BYTE; res[n].data = dig1_r; n = n + 1'b1;
            p = plain(b, quote_r, flags);
            take_p = 1'b1;
          end
        end
        M_DIG2: begin
          mode_nxt = M_TOKEN;
          if (is_digit(b)) begin
            // only the low byte of the octal sum survives
            oct = {dig1_r[1:0], 6'b0} + {dig2_r[4:0], 3'b0} + b - OCTAL_BIAS[BYTE_W-1:0];
            res[n].kind = K_BYTE; res[n].data = oct; n = n + 1'b1;
          end else begin
            res[n].kind = K_BYTE; res[n].data = dig1_r; n = n + 1'b1;
            res[n].kind = K_BYTE; res[n].data = dig2_r; n = n + 1'b1;
            p = plain(b, quote_r, flags);
            take_p = 1'b1;
          end
        end
        M_CARET: begin
          mode_nxt = M_TOKEN;
          res[n].kind = K_BYTE;
          if (b == "^") begin
            res[n].data = "^"; n = n + 1'b1;
          end else if (b == "[") begin
            res[n].data = ESC_BYTE; n = n + 1'b1;
          end else if (is_alpha(b)) begin
            res[n].data = to_upper(b) - CARET_BASE; n = n + 1'b1;
          end else begin
            res[n].data = "^"; n = n + 1'b1;
            res[n].kind = K_BYTE; res[n].data = b; n = n + 1'b1;
          end
        end
        default: begin
          p = plain(b, quote_r, flags);
          take_p = 1'b1;
        end
      endcase

      // modes that fall into the plain byte path
      if (take_p) begin
        mode_nxt  = p.mode;
        quote_nxt = p.quote;
        if (p.emit) begin
          res[n].kind = p.kind; res[n].data = p.data; n = n + 1'b1;
        end
      end
    end

    if (n != '0) begin
      res[n - 1'b1].last = 1'b1;
    end
    res_cnt = n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= M_SKIP;
      quote_r <= Q_NONE;
      dig1_r  <= '0;
      dig2_r  <= '0;
    end else if (load) begin
      mode_r  <= mode_nxt;
      quote_r <= quote_nxt;
      dig1_r  <= dig1_nxt;
      dig2_r  <= dig2_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== sv/qts_outbuf.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qts_outbuf
// result register: holds the results of one byte and hands them out a beat each
// ----------------------------------------------------------------------------
module qts_outbuf import qts_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  load,
  input  res_t      [NRES-1:0]       res,
  input  wire logic [CNT_W-1:0]      res_cnt,
  output logic                       buf_free,
  qts_out_if.source                  out_ch
);

  res_t [NRES-1:0]  ent_r;
  logic [CNT_W-1:0] rd_r;
  logic [CNT_W-1:0] rem_r;
  logic             fire;
  res_t             head;

  assign head           = ent_r[rd_r];
  assign out_ch.valid    = (rem_r != '0);
  assign out_ch.kind     = head.kind;
  assign out_ch.out_byte = head.data;
  assign out_ch.last     = head.last;
  assign fire            = out_ch.valid & out_ch.ready;
  // free when empty or the final beat leaves this cycle
  assign buf_free        = (rem_r == '0) || (rem_r == 2'd1 && fire);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r  <= '0;
      rem_r <= '0;
    end else if (load) begin
      rd_r  <= '0;
      rem_r <= res_cnt;
    end else if (fire) begin
      rd_r  <= rd_r + 1'b1;
      rem_r <= rem_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ent_r <= res;
    end
  end

  a_load_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> (rem_r == '0) || (rem_r == 2'd1 && fire))
    else $error("results loaded over pending results");

  a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, rd_r} + {1'b0, rem_r}) <= 3'd3)
    else $error("read pointer past stored results");

  a_last_on_final: assert property (@(posedge clk) disable iff (!rst_n)
    (rem_r == 2'd1) |-> head.last)
    else $error("final result of a byte lacks last");

  a_empty_load: assert property (@(posedge clk) disable iff (!rst_n)
    (load && res_cnt == '0) |=> !out_ch.valid)
    else $error("result shown for a byte that gives none");

endmodule
`default_nettype wire

// ===== sv/quoted_token_splitter.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// quoted_token_splitter
// Splits a line, one byte per input beat, into shell-style tokens. A beat with
// line_end set closes the line. Each input beat gives zero to three result
// beats on out_ch: decoded bytes, a token end carrying the stopping delimiter
// (zero at a line end), or an error when an escape is cut off by the line end;
// last marks the final result of an input beat.
// An accepted beat is held in the input register and is decoded into the
// result register once that register is free; its first result is then valid
// on out_ch. While out_ch does not stall, a byte with at most one result is
// taken every cycle; a byte with more results holds the input side until they
// have drained, the rate being set by the single result register that drains
// one beat per cycle while out_ch is ready.
// Reset (rst_n low, synchronous) clears the flags, the scan state and the valid
// state of both registers. When out_ch stalls, the result register holds and the
// input register fills, after which in_ch.ready drops; nothing is dropped.
// token_flags is written at addresses 0 to 3 of the register port (paddr[2] low).
// ----------------------------------------------------------------------------
module quoted_token_splitter import qts_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  qts_in_if.sink                 in_ch,
  qts_out_if.source              out_ch,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [CFG_DW-1:0] pwdata,
  output logic      [CFG_DW-1:0] prdata,
  output logic                   pready
);

  logic [FLAG_W-1:0] flags;
  logic              buf_free;
  logic              load;
  res_t [NRES-1:0]   res;
  logic [CNT_W-1:0]  res_cnt;

  qts_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .flags   (flags)
  );

  qts_decode u_decode (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .flags    (flags),
    .buf_free (buf_free),
    .load     (load),
    .res      (res),
    .res_cnt  (res_cnt)
  );

  qts_outbuf u_outbuf (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (load),
    .res      (res),
    .res_cnt  (res_cnt),
    .buf_free (buf_free),
    .out_ch   (out_ch)
  );

endmodule
`default_nettype wire
